// ===== design/ratiometric_temperature_smoother_macros.svh =====
// Assertion macros used by the datapath.
`ifndef RATIOMETRIC_TEMPERATURE_SMOOTHER_MACROS_SVH
`define RATIOMETRIC_TEMPERATURE_SMOOTHER_MACROS_SVH

// Assert that prop implies cons on the same edge.
`define RTS_ASSERT_IMP(label, clk, rst, prop, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (prop) |-> (cons)) \
      else $error("assertion failed");

// Assert that prop implies cons on the next edge.
`define RTS_ASSERT_NEXT(label, clk, rst, prop, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (prop) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/rts_pkg.sv =====
`timescale 1ns / 1ps
package rts_pkg;
   localparam int BlockLenDefault = 64;
   localparam int SmoothLenDefault = 8;
   localparam int NumCh = 6;
   localparam int NumPairs = 3;
   localparam int SampleW = 12;
   localparam int SumW = 20;
   localparam int TempW = 16;
   localparam int OffW = 11;
   localparam int ChW = 3;
   localparam int Gain = 2361;
   localparam int Bias = 2597;
   localparam logic [1:0] CsrSupply = 2'd0;
   localparam logic [1:0] CsrReturn = 2'd1;
   localparam logic [1:0] CsrAmbient = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AVG, ST_FILL, ST_RSUM, ST_LEVEL, ST_DIVLOAD, ST_DIVRUN, ST_PAIR,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic clear_ch;    // reset channel counter
      logic avg_step;    // compute average of current channel
      logic fill_step;   // write ring entry (first pass fill)
      logic rsum_step;   // accumulate one ring entry
      logic level_step;  // store level, advance channel
      logic div_load;
      logic div_step;
      logic pair_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic fill_done;
      logic rsum_done;
      logic ch_done;
      logic div_done;
      logic pair_done;
   } status_type;
endpackage

// ===== design/rts_if.sv =====
`timescale 1ns / 1ps
interface rts_req_if;
   logic valid;
   logic ready;
   logic [11:0] sample;
   logic [2:0] channel;
   logic last;
   modport source (output valid, sample, channel, last, input ready);
   modport sink (input valid, sample, channel, last, output ready);
endinterface

interface rts_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] supply_display;
   logic signed [15:0] return_display;
   logic signed [15:0] ambient_display;
   logic [2:0] divide_fault;
   modport source (output valid, supply_display, return_display, ambient_display,
      divide_fault, input ready);
   modport sink (input valid, supply_display, return_display, ambient_display,
      divide_fault, output ready);
endinterface

// ===== design/ratiometric_temperature_smoother.sv =====
`timescale 1ns / 1ps
// Ratiometric temperature smoother.
// req channel: one word per converter sample (sample, channel, last).
// Samples are summed per channel as they arrive; a word without last
// returns no result and ready stays high.
// A word with last starts the end-of-block sequence: per channel an average
// step with a ring write and a ring sum (a ring fill on the first pass),
// then per pair a 24-bit restoring divider and a slew step.
// req ready is low during the sequence and while the result waits.
// rsp channel: one word per block with three display values and the
// divide fault bits; the word is held in an output register while rsp
// ready is low, and the block resumes taking samples once it is taken.
// csr port: write offsets for supply, return and ambient pairs while idle.
// Reset (synchronous, active high) clears sums, levels, displays, offsets
// and marks the next block as the first pass, which fills the ring.
module ratiometric_temperature_smoother #(
   parameter int BLOCK_LEN = rts_pkg::BlockLenDefault,
   parameter int SMOOTH_LEN = rts_pkg::SmoothLenDefault
) (
   input logic clock,
   input logic reset,
   rts_req_if.sink req,
   rts_rsp_if.source rsp,
   input logic csr_write,
   input logic [1:0] csr_index,
   input logic [rts_pkg::OffW-1:0] csr_data
);
   rts_pkg::cmd_type cmd;
   rts_pkg::status_type status;
   logic idle, acc_en, start;
   logic valid_ff;
   logic signed [rts_pkg::TempW-1:0] disp [rts_pkg::NumPairs];
   logic [rts_pkg::NumPairs-1:0] fault;

   assign req.ready = idle;
   assign acc_en = req.valid && idle;
   assign start = acc_en && req.last;

   rts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .rsp_busy(valid_ff && !rsp.ready),
      .status(status), .cmd(cmd), .idle(idle)
   );

   rts_datapath #(.BLOCK_LEN(BLOCK_LEN), .SMOOTH_LEN(SMOOTH_LEN)) u_dp (
      .clock(clock), .reset(reset), .acc_en(acc_en), .acc_sample(req.sample),
      .acc_channel(req.channel), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .cmd(cmd), .status(status), .disp_out(disp),
      .fault_out(fault)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.pair_step && status.pair_done) valid_ff <= 1'b1;
      else if (rsp.ready) valid_ff <= 1'b0;
   end

   assign rsp.valid = valid_ff;
   assign rsp.supply_display = disp[0];
   assign rsp.return_display = disp[1];
   assign rsp.ambient_display = disp[2];
   assign rsp.divide_fault = fault;
endmodule

// ===== design/rts_ctrl.sv =====
`timescale 1ns / 1ps
module rts_ctrl (
   input logic clock,
   input logic reset,
   input logic start,
   input logic rsp_busy,
   input rts_pkg::status_type status,
   output rts_pkg::cmd_type cmd,
   output logic idle
);
   rts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rts_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rts_pkg::ST_IDLE: if (start) state_in = rts_pkg::ST_AVG;
         rts_pkg::ST_AVG: state_in = status.first ? rts_pkg::ST_FILL : rts_pkg::ST_RSUM;
         rts_pkg::ST_FILL: if (status.fill_done) state_in = rts_pkg::ST_LEVEL;
         rts_pkg::ST_RSUM: if (status.rsum_done) state_in = rts_pkg::ST_LEVEL;
         rts_pkg::ST_LEVEL: state_in = status.ch_done ? rts_pkg::ST_DIVLOAD : rts_pkg::ST_AVG;
         rts_pkg::ST_DIVLOAD: state_in = rts_pkg::ST_DIVRUN;
         rts_pkg::ST_DIVRUN: if (status.div_done) state_in = rts_pkg::ST_PAIR;
         rts_pkg::ST_PAIR: state_in = status.pair_done ? rts_pkg::ST_SEND
                                                       : rts_pkg::ST_DIVLOAD;
         rts_pkg::ST_SEND: if (!rsp_busy) state_in = rts_pkg::ST_IDLE;
         default: state_in = rts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      idle = 1'b0;
      unique case (state_ff)
         rts_pkg::ST_IDLE: begin
            idle = 1'b1;
            cmd.clear_ch = 1'b1;
         end
         rts_pkg::ST_AVG: cmd.avg_step = 1'b1;
         rts_pkg::ST_FILL: cmd.fill_step = 1'b1;
         rts_pkg::ST_RSUM: cmd.rsum_step = 1'b1;
         rts_pkg::ST_LEVEL: cmd.level_step = 1'b1;
         rts_pkg::ST_DIVLOAD: cmd.div_load = 1'b1;
         rts_pkg::ST_DIVRUN: cmd.div_step = 1'b1;
         rts_pkg::ST_PAIR: cmd.pair_step = 1'b1;
         rts_pkg::ST_SEND: cmd.finish = !rsp_busy;
         default: cmd = '0;
      endcase
   end
endmodule

// ===== design/rts_datapath.sv =====
`timescale 1ns / 1ps
`include "ratiometric_temperature_smoother_macros.svh"
module rts_datapath #(
   parameter int BLOCK_LEN = rts_pkg::BlockLenDefault,
   parameter int SMOOTH_LEN = rts_pkg::SmoothLenDefault
) (
   input logic clock,
   input logic reset,
   input logic acc_en,
   input logic [rts_pkg::SampleW-1:0] acc_sample,
   input logic [rts_pkg::ChW-1:0] acc_channel,
   input logic csr_write,
   input logic [1:0] csr_index,
   input logic [rts_pkg::OffW-1:0] csr_data,
   input rts_pkg::cmd_type cmd,
   output rts_pkg::status_type status,
   output logic signed [rts_pkg::TempW-1:0] disp_out [rts_pkg::NumPairs],
   output logic [rts_pkg::NumPairs-1:0] fault_out
);
   localparam int PosW = (SMOOTH_LEN > 1) ? $clog2(SMOOTH_LEN) : 1;
   localparam int RingD = rts_pkg::NumCh * SMOOTH_LEN;
   localparam int AddrW = $clog2(RingD);
   localparam int RsW = rts_pkg::SampleW + $clog2(SMOOTH_LEN + 1);
   localparam int QW = 24;

   logic [rts_pkg::SumW-1:0] sums_ff [rts_pkg::NumCh];
   logic signed [rts_pkg::OffW-1:0] off_ff [rts_pkg::NumPairs];
   logic [rts_pkg::SampleW-1:0] ring_mem [RingD];
   logic [rts_pkg::SampleW-1:0] rd_ff;
   logic rd_valid_ff;
   logic [PosW-1:0] pos_ff;
   logic [PosW:0] idx_ff;
   logic [2:0] ch_ff;
   logic [1:0] pair_ff;
   logic [rts_pkg::SampleW-1:0] avg_ff;
   logic [RsW-1:0] rsum_ff;
   logic [rts_pkg::SampleW-1:0] lvl_ff [rts_pkg::NumCh];
   logic signed [rts_pkg::TempW-1:0] temp_ff [rts_pkg::NumPairs];
   logic signed [rts_pkg::TempW-1:0] disp_ff [rts_pkg::NumPairs];
   logic [rts_pkg::NumPairs-1:0] fault_ff;
   logic first_ff;
   logic [QW-1:0] num_ff, quo_ff;
   logic [rts_pkg::SampleW:0] rem_ff;
   logic [4:0] dcnt_ff;

   logic [rts_pkg::SumW-1:0] avg_full;
   logic [AddrW-1:0] waddr, raddr;
   logic ring_we;
   logic [rts_pkg::SampleW:0] rem_sh;
   logic [rts_pkg::SampleW-1:0] den;
   logic signed [QW+2:0] t_wide;
   logic signed [rts_pkg::TempW-1:0] t_sat, t_use, d_cur, d_new;
   logic [2:0] ch_sel;

   assign avg_full = rts_pkg::SumW'(sums_ff[ch_ff] / BLOCK_LEN);
   assign den = lvl_ff[{pair_ff, 1'b1}];
   assign ring_we = cmd.fill_step || (cmd.avg_step && !first_ff);
   assign waddr = AddrW'(ch_ff * SMOOTH_LEN) +
      AddrW'(cmd.fill_step ? idx_ff[PosW-1:0] : pos_ff);
   assign raddr = AddrW'(ch_ff * SMOOTH_LEN) + AddrW'(idx_ff[PosW-1:0]);
   assign ch_sel = acc_channel;

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[waddr] <= cmd.fill_step ? avg_ff :
         ((avg_full > 20'd4095) ? 12'd4095 : avg_full[rts_pkg::SampleW-1:0]);
      rd_ff <= ring_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rts_pkg::NumCh; i++) begin
            sums_ff[i] <= '0;
            lvl_ff[i] <= '0;
         end
         for (int i = 0; i < rts_pkg::NumPairs; i++) begin
            off_ff[i] <= '0;
            temp_ff[i] <= '0;
            disp_ff[i] <= '0;
         end
         pos_ff <= '0;
         first_ff <= 1'b1;
         idx_ff <= '0;
         ch_ff <= '0;
         pair_ff <= '0;
         fault_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               rts_pkg::CsrSupply: off_ff[0] <= csr_data;
               rts_pkg::CsrReturn: off_ff[1] <= csr_data;
               rts_pkg::CsrAmbient: off_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (acc_en && ch_sel < 3'd6) begin
            if ({1'b0, sums_ff[ch_sel]} + 21'(acc_sample) > 21'hFFFFF)
               sums_ff[ch_sel] <= 20'hFFFFF;
            else sums_ff[ch_sel] <= sums_ff[ch_sel] + 20'(acc_sample);
         end
         rd_valid_ff <= cmd.rsum_step && (idx_ff <= (PosW+1)'(SMOOTH_LEN - 1));
         if (cmd.clear_ch) begin
            ch_ff <= '0;
            pair_ff <= '0;
            fault_ff <= '0;
         end
         if (cmd.avg_step) begin
            avg_ff <= (avg_full > 20'd4095) ? 12'd4095 : avg_full[rts_pkg::SampleW-1:0];
            sums_ff[ch_ff] <= '0;
            idx_ff <= '0;
            rsum_ff <= '0;
         end
         if (cmd.fill_step) idx_ff <= idx_ff + 1'b1;
         if (cmd.rsum_step) begin
            if (idx_ff <= (PosW+1)'(SMOOTH_LEN - 1)) idx_ff <= idx_ff + 1'b1;
            if (rd_valid_ff) rsum_ff <= rsum_ff + RsW'(rd_ff);
         end
         if (cmd.level_step) begin
            lvl_ff[ch_ff] <= first_ff ? avg_ff : 12'(rsum_ff / SMOOTH_LEN);
            ch_ff <= ch_ff + 1'b1;
         end
         if (cmd.div_load) begin
            num_ff <= QW'(lvl_ff[{pair_ff, 1'b0}] * rts_pkg::Gain);
            quo_ff <= '0;
            rem_ff <= '0;
            dcnt_ff <= '0;
         end
         if (cmd.div_step) begin
            rem_ff <= (rem_sh >= {1'b0, den}) ? rem_sh - {1'b0, den} : rem_sh;
            quo_ff <= {quo_ff[QW-2:0], rem_sh >= {1'b0, den}};
            num_ff <= {num_ff[QW-2:0], 1'b0};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         if (cmd.pair_step) begin
            if (den == '0) fault_ff[pair_ff] <= 1'b1;
            else temp_ff[pair_ff] <= t_sat;
            disp_ff[pair_ff] <= d_new;
            pair_ff <= pair_ff + 1'b1;
         end
         if (cmd.finish) begin
            first_ff <= 1'b0;
            if (!first_ff) pos_ff <= (pos_ff == PosW'(SMOOTH_LEN - 1)) ? '0 : pos_ff + 1'b1;
         end
      end
   end

   assign rem_sh = {rem_ff[rts_pkg::SampleW-1:0], num_ff[QW-1]};

   always_comb begin
      t_wide = $signed({3'b0, quo_ff}) - (QW+3)'(rts_pkg::Bias) +
         (QW+3)'(off_ff[pair_ff]);
      if (t_wide > 32767) t_sat = 16'sh7FFF;
      else if (t_wide < -32768) t_sat = -16'sh8000;
      else t_sat = t_wide[rts_pkg::TempW-1:0];
      t_use = (den == '0) ? temp_ff[pair_ff] : t_sat;
      d_cur = first_ff ? t_use : disp_ff[pair_ff];
      if (18'(d_cur) < 18'(t_use) - 18'sd1) d_new = d_cur + 16'sd1;
      else if (18'(d_cur) > 18'(t_use) + 18'sd1) d_new = d_cur - 16'sd1;
      else d_new = d_cur;
   end

   assign status.first = first_ff;
   assign status.fill_done = idx_ff == (PosW+1)'(SMOOTH_LEN - 1) && cmd.fill_step;
   assign status.rsum_done = idx_ff == (PosW+1)'(SMOOTH_LEN) && !rd_valid_ff &&
      cmd.rsum_step;
   assign status.ch_done = ch_ff == 3'd5;
   assign status.div_done = dcnt_ff == 5'(QW - 1);
   assign status.pair_done = pair_ff == 2'd2;

   always_comb begin
      for (int i = 0; i < rts_pkg::NumPairs; i++) disp_out[i] = disp_ff[i];
   end
   assign fault_out = fault_ff;

   `RTS_ASSERT_IMP(a_ch_range, clock, reset, cmd.level_step, ch_ff < 3'd6)
   `RTS_ASSERT_IMP(a_pair_range, clock, reset, cmd.pair_step, pair_ff < 2'd3)
   `RTS_ASSERT_NEXT(a_first_clears, clock, reset, cmd.finish, !first_ff)
endmodule
